// ===== design/arc_pkg.sv =====
// Shared types and status codes for the alert retransmit controller.
package arc_pkg;

   // Alert status codes as they appear on the result channel
   localparam logic [1:0] STATUS_IDLE      = 2'd0;
   localparam logic [1:0] STATUS_AWAIT     = 2'd1;
   localparam logic [1:0] STATUS_DELIVERED = 2'd2;
   localparam logic [1:0] STATUS_FAILED    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE_US    = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT_MS = 2'd1;
   localparam logic [1:0] CSR_MAX_ATTEMPTS   = 2'd2;

   // Configuration reset values
   localparam logic [31:0] DEBOUNCE_US_RST    = 32'd200000;
   localparam logic [15:0] ACK_TIMEOUT_MS_RST = 16'd1000;
   localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd3;

   typedef struct packed {
      logic [31:0] debounce_us;
      logic [15:0] ack_timeout_ms;
      logic [7:0]  max_attempts;
   } arc_cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] sequence_count;
      logic [7:0]  attempt_count;
      logic [31:0] last_press_us;
      logic [31:0] last_send_ms;
      logic        led_level;
   } arc_state_type;

   typedef struct packed {
      logic        press_seen;
      logic [31:0] press_time_us;
      logic        ack_valid;
      logic [31:0] ack_sequence;
      logic [31:0] now_ms;
   } arc_item_type;

   typedef struct packed {
      logic        send_alert;
      logic [31:0] alert_sequence;
      logic [31:0] alert_time_ms;
      logic [1:0]  alert_status;
      logic        status_led;
      logic        delivered_now;
      logic        failed_now;
   } arc_rsp_type;

endpackage

// ===== design/arc_blink.sv =====
// Failure blink phase: bit 0 of now_ms / 250 by reciprocal multiplication.
module arc_blink (
   input  logic [31:0] now_ms,
   output logic        blink
);

   // now / 250 == (now >> 1) / 125; 125 is handled as a multiply by
   // ceil(2^38 / 125), exact for all 31-bit dividends.
   localparam int unsigned  BLINK_SHIFT = 38;
   localparam logic [31:0]  BLINK_RECIP = 32'd2199023256;

   logic [62:0] product;

   assign product = 63'(now_ms[31:1]) * 63'(BLINK_RECIP);
   assign blink   = product[BLINK_SHIFT];

endmodule

// ===== design/arc_core.sv =====
// Single-pass update: press, ack, timeout/retry and blink for one item.
module arc_core (
   input  arc_pkg::arc_cfg_type   cfg,
   input  arc_pkg::arc_state_type cur,
   input  arc_pkg::arc_item_type  item,
   input  logic                   blink,
   output arc_pkg::arc_state_type nxt,
   output arc_pkg::arc_rsp_type   rsp
);

   logic press_ok;
   logic timed_out;
   logic sent;
   logic delivered;
   logic failed;

   always_comb begin
      nxt       = cur;
      sent      = 1'b0;
      delivered = 1'b0;
      failed    = 1'b0;

      // accept a debounced press: bump the sequence and transmit
      press_ok = item.press_seen &&
                 ((item.press_time_us - cur.last_press_us) >= cfg.debounce_us);
      if (press_ok) begin
         nxt.last_press_us  = item.press_time_us;
         nxt.sequence_count = cur.sequence_count + 32'd1;
         nxt.attempt_count  = 8'd1;
         nxt.last_send_ms   = item.now_ms;
         nxt.status         = arc_pkg::STATUS_AWAIT;
         nxt.led_level      = 1'b1;
         sent               = 1'b1;
      end

      // matching ack marks delivery in any state
      if (item.ack_valid && (item.ack_sequence == nxt.sequence_count)) begin
         nxt.status    = arc_pkg::STATUS_DELIVERED;
         nxt.led_level = 1'b0;
         delivered     = 1'b1;
      end

      // retransmit on timeout, or give up at the attempt limit
      timed_out = (item.now_ms - nxt.last_send_ms) >= {16'd0, cfg.ack_timeout_ms};
      if ((nxt.status == arc_pkg::STATUS_AWAIT) && timed_out) begin
         if (nxt.attempt_count < cfg.max_attempts) begin
            nxt.attempt_count = nxt.attempt_count + 8'd1;
            nxt.last_send_ms  = item.now_ms;
            nxt.status        = arc_pkg::STATUS_AWAIT;
            nxt.led_level     = 1'b1;
            sent              = 1'b1;
         end else begin
            nxt.status = arc_pkg::STATUS_FAILED;
            failed     = 1'b1;
         end
      end

      // blink while failed
      if (nxt.status == arc_pkg::STATUS_FAILED) begin
         nxt.led_level = blink;
      end

      rsp.send_alert     = sent;
      rsp.alert_sequence = nxt.sequence_count;
      rsp.alert_time_ms  = nxt.last_send_ms;
      rsp.alert_status   = nxt.status;
      rsp.status_led     = nxt.led_level;
      rsp.delivered_now  = delivered;
      rsp.failed_now     = failed;
   end

endmodule

// ===== design/alert_retransmit_controller.sv =====
// Top level of the alert retransmit controller.
//
// Usage: each req_ item is one main-loop pass (press capture, ack, time).
// Every accepted item yields exactly one rsp_ item carrying the transmit
// flag, sequence, last send time, status, LED level and event flags.
// Configuration is written through the csr_ channel (index 0 debounce,
// 1 ack timeout, 2 max attempts); csr_ready is always high and writes
// are meant to happen while no item is in flight.
// Path: an item passes the input register, then the result register,
// before it shows on rsp_. Throughput: one item per cycle while rsp_
// is not stalled; the state update of one item is complete in the cycle
// it leaves the input register, so the next item sees it directly.
// Reset: synchronous, active high; status idle, sequence and times zero,
// LED off, registers back to 200000 us, 1000 ms and 3 attempts.
// Stall: while rsp_ready is low the result holds, the input register
// holds one more item, and req_ready drops only once both are full.
module alert_retransmit_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_press_seen,
   input  logic [31:0] req_press_time_us,
   input  logic        req_ack_valid,
   input  logic [31:0] req_ack_sequence,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_alert,
   output logic [31:0] rsp_alert_sequence,
   output logic [31:0] rsp_alert_time_ms,
   output logic [1:0]  rsp_alert_status,
   output logic        rsp_status_led,
   output logic        rsp_delivered_now,
   output logic        rsp_failed_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   arc_pkg::arc_cfg_type   cfg_ff;
   arc_pkg::arc_state_type state_ff;
   arc_pkg::arc_state_type state_in;
   arc_pkg::arc_item_type  item_ff;
   arc_pkg::arc_item_type  item_in;
   arc_pkg::arc_rsp_type   rsp_ff;
   arc_pkg::arc_rsp_type   rsp_in;
   logic                   in_valid_ff;
   logic                   rsp_valid_ff;
   logic                   blink_ff;
   logic                   blink_in;
   logic                   advance;
   logic                   req_take;

   // handshake control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign item_in.press_seen    = req_press_seen;
   assign item_in.press_time_us = req_press_time_us;
   assign item_in.ack_valid     = req_ack_valid;
   assign item_in.ack_sequence  = req_ack_sequence;
   assign item_in.now_ms        = req_now_ms;

   arc_blink u_blink (
      .now_ms (req_now_ms),
      .blink  (blink_in)
   );

   arc_core u_core (
      .cfg   (cfg_ff),
      .cur   (state_ff),
      .item  (item_ff),
      .blink (blink_ff),
      .nxt   (state_in),
      .rsp   (rsp_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_us    <= arc_pkg::DEBOUNCE_US_RST;
         cfg_ff.ack_timeout_ms <= arc_pkg::ACK_TIMEOUT_MS_RST;
         cfg_ff.max_attempts   <= arc_pkg::MAX_ATTEMPTS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            arc_pkg::CSR_DEBOUNCE_US:    cfg_ff.debounce_us    <= csr_wdata;
            arc_pkg::CSR_ACK_TIMEOUT_MS: cfg_ff.ack_timeout_ms <= csr_wdata[15:0];
            arc_pkg::CSR_MAX_ATTEMPTS:   cfg_ff.max_attempts   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture the item and its blink phase
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff  <= item_in;
         blink_ff <= blink_in;
      end
   end

   // commit controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.status         <= arc_pkg::STATUS_IDLE;
         state_ff.sequence_count <= 32'd0;
         state_ff.attempt_count  <= 8'd0;
         state_ff.last_press_us  <= 32'd0;
         state_ff.last_send_ms   <= 32'd0;
         state_ff.led_level      <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_alert     = rsp_ff.send_alert;
   assign rsp_alert_sequence = rsp_ff.alert_sequence;
   assign rsp_alert_time_ms  = rsp_ff.alert_time_ms;
   assign rsp_alert_status   = rsp_ff.alert_status;
   assign rsp_status_led     = rsp_ff.status_led;
   assign rsp_delivered_now  = rsp_ff.delivered_now;
   assign rsp_failed_now     = rsp_ff.failed_now;

endmodule

// ===== design/arc_checker.sv =====
// Port-level checks for the alert retransmit controller, bound to the top.
module arc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_send_alert,
   input logic [31:0] rsp_alert_sequence,
   input logic [1:0]  rsp_alert_status,
   input logic        rsp_status_led,
   input logic        rsp_delivered_now,
   input logic        rsp_failed_now
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alert_sequence))
      else $error("stalled result changed");

   // a transmission never leaves the alert idle
   a_send_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_alert |->
         (rsp_alert_status != arc_pkg::STATUS_IDLE))
      else $error("transmission with idle status");

   // delivery ends the pass delivered, with no failure
   a_delivered_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delivered_now |->
         (rsp_alert_status == arc_pkg::STATUS_DELIVERED) && !rsp_failed_now
         && !rsp_status_led)
      else $error("delivery flag with wrong status");

   // failure flag only with failed status
   a_failed_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed_now |->
         (rsp_alert_status == arc_pkg::STATUS_FAILED))
      else $error("failure flag with wrong status");

endmodule

bind alert_retransmit_controller arc_checker u_arc_checker (.*);

// ===== verif/tb_alert_retransmit_controller.sv =====
// Testbench for the alert retransmit controller: directed, then random passes.
`timescale 1ns / 100ps

module tb_alert_retransmit_controller;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int RSP_LATENCY   = 2;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_PASSES  = 200;
   localparam int IDLE_PCT      = 14;
   localparam logic [31:0] BLINK_HALF_MS = 32'd250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_press_seen = 1'b0;
   logic [31:0] req_press_time_us = '0;
   logic        req_ack_valid = 1'b0;
   logic [31:0] req_ack_sequence = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_send_alert;
   logic [31:0] rsp_alert_sequence;
   logic [31:0] rsp_alert_time_ms;
   logic [1:0]  rsp_alert_status;
   logic        rsp_status_led;
   logic        rsp_delivered_now;
   logic        rsp_failed_now;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = arc_pkg::CSR_DEBOUNCE_US;
   logic [31:0] csr_wdata = '0;

   alert_retransmit_controller dut (.*);

   always #CLK_HALF clock = ~clock;

   // Controller state as the testbench tracks it
   arc_pkg::arc_cfg_type   ctl_cfg;
   arc_pkg::arc_state_type ctl_state;
   arc_pkg::arc_rsp_type   results_due[$];
   int                     fail_count = 0;
   int                     cycle_count = 0;
   int                     send_idle_pct = IDLE_PCT;
   int                     recv_idle_pct = IDLE_PCT;

   typedef struct {
      bit                    new_cfg;
      arc_pkg::arc_cfg_type  cfg;
      arc_pkg::arc_item_type pass;
      bit                    typed;
      arc_pkg::arc_rsp_type  want;
   } pass_row_type;

   pass_row_type directed_passes[$];

   // Send one alert frame: count the attempt and restart the ack timer
   function automatic void transmit_frame(input logic [31:0] now);
      ctl_state.attempt_count = ctl_state.attempt_count + 8'd1;
      ctl_state.last_send_ms  = now;
      ctl_state.status        = arc_pkg::STATUS_AWAIT;
      ctl_state.led_level     = 1'b1;
   endfunction

   // Run one main-loop pass on the tracked state and return its result
   function automatic arc_pkg::arc_rsp_type predict_pass(input arc_pkg::arc_item_type it);
      arc_pkg::arc_rsp_type r;
      logic [31:0] blink_slot;
      r = '0;
      // accept a debounced press and start a fresh alert
      if (it.press_seen &&
          (it.press_time_us - ctl_state.last_press_us) >= ctl_cfg.debounce_us) begin
         ctl_state.last_press_us  = it.press_time_us;
         ctl_state.sequence_count = ctl_state.sequence_count + 32'd1;
         ctl_state.attempt_count  = '0;
         transmit_frame(it.now_ms);
         r.send_alert = 1'b1;
      end
      // a matching ack delivers in any state
      if (it.ack_valid && it.ack_sequence == ctl_state.sequence_count) begin
         ctl_state.status    = arc_pkg::STATUS_DELIVERED;
         ctl_state.led_level = 1'b0;
         r.delivered_now     = 1'b1;
      end
      // retransmit on timeout until the attempt budget is spent
      if (ctl_state.status == arc_pkg::STATUS_AWAIT &&
          (it.now_ms - ctl_state.last_send_ms) >= ctl_cfg.ack_timeout_ms) begin
         if (ctl_state.attempt_count < ctl_cfg.max_attempts) begin
            transmit_frame(it.now_ms);
            r.send_alert = 1'b1;
         end else begin
            ctl_state.status = arc_pkg::STATUS_FAILED;
            r.failed_now     = 1'b1;
         end
      end
      // blink while failed
      if (ctl_state.status == arc_pkg::STATUS_FAILED) begin
         blink_slot = it.now_ms / BLINK_HALF_MS;
         ctl_state.led_level = blink_slot[0];
      end
      r.alert_sequence = ctl_state.sequence_count;
      r.alert_time_ms  = ctl_state.last_send_ms;
      r.alert_status   = ctl_state.status;
      r.status_led     = ctl_state.led_level;
      return r;
   endfunction

   function automatic void add_pass(input bit typed, input logic press,
                                    input logic [31:0] press_us, input logic ack,
                                    input logic [31:0] ack_seq, input logic [31:0] now,
                                    input arc_pkg::arc_rsp_type want);
      pass_row_type row;
      row = '{default: '0};
      row.pass  = {press, press_us, ack, ack_seq, now};
      row.typed = typed;
      row.want  = want;
      directed_passes.push_back(row);
   endfunction

   function automatic void add_cfg(input arc_pkg::arc_cfg_type c);
      pass_row_type row;
      row = '{default: '0};
      row.new_cfg = 1'b1;
      row.cfg     = c;
      directed_passes.push_back(row);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Present one pass, with random gaps ahead of it, and hold it until taken
   task automatic drive_pass(input arc_pkg::arc_item_type it,
                             input arc_pkg::arc_rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      results_due.push_back(want);
      req_valid         <= 1'b1;
      req_press_seen    <= it.press_seen;
      req_press_time_us <= it.press_time_us;
      req_ack_valid     <= it.ack_valid;
      req_ack_sequence  <= it.ack_sequence;
      req_now_ms        <= it.now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Hold off new passes until every result is back, then load all registers
   task automatic load_config(input arc_pkg::arc_cfg_type c);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      write_csr(arc_pkg::CSR_DEBOUNCE_US, c.debounce_us);
      write_csr(arc_pkg::CSR_ACK_TIMEOUT_MS, {16'($urandom()), c.ack_timeout_ms});
      write_csr(arc_pkg::CSR_MAX_ATTEMPTS, {24'($urandom()), c.max_attempts});
      csr_valid <= 1'b0;
      ctl_cfg = c;
   endtask

   // Take results with random stalls and compare against the oldest expectation
   always @(posedge clock) begin : take_results
      arc_pkg::arc_rsp_type due;
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, actual sequence %0h status %0h",
                        $time, rsp_alert_sequence, rsp_alert_status);
            end else begin
               due = results_due.pop_front();
               check_field("send_alert", due.send_alert, rsp_send_alert);
               check_field("alert_sequence", due.alert_sequence, rsp_alert_sequence);
               check_field("alert_time_ms", due.alert_time_ms, rsp_alert_time_ms);
               check_field("alert_status", due.alert_status, rsp_alert_status);
               check_field("status_led", due.status_led, rsp_status_led);
               check_field("delivered_now", due.delivered_now, rsp_delivered_now);
               check_field("failed_now", due.failed_now, rsp_failed_now);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      arc_pkg::arc_rsp_type  want;
      arc_pkg::arc_item_type it;
      arc_pkg::arc_cfg_type  c;
      logic [31:0]           now_ms;
      logic [31:0]           press_us;
      longint unsigned       span;
      int                    pick;

      ctl_cfg.debounce_us    = arc_pkg::DEBOUNCE_US_RST;
      ctl_cfg.ack_timeout_ms = arc_pkg::ACK_TIMEOUT_MS_RST;
      ctl_cfg.max_attempts   = arc_pkg::MAX_ATTEMPTS_RST;
      ctl_state              = '0;
      ctl_state.status       = arc_pkg::STATUS_IDLE;

      // Reset configuration: debounce 200000 us, timeout 1000 ms, 3 attempts
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0,
               {1'b0, 32'd0, 32'd0, arc_pkg::STATUS_IDLE, 1'b0, 1'b0, 1'b0});
      // ack for sequence zero matches right after reset
      add_pass(1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd5,
               {1'b0, 32'd0, 32'd0, arc_pkg::STATUS_DELIVERED, 1'b0, 1'b1, 1'b0});
      // press too soon after reset is dropped
      add_pass(1, 1'b1, 32'd199999, 1'b0, 32'd0, 32'd10,
               {1'b0, 32'd0, 32'd0, arc_pkg::STATUS_DELIVERED, 1'b0, 1'b0, 1'b0});
      add_pass(1, 1'b1, 32'd200000, 1'b0, 32'd0, 32'd100,
               {1'b1, 32'd1, 32'd100, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd1099,
               {1'b0, 32'd1, 32'd100, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      // retries until the budget is spent, then blink
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd1100,
               {1'b1, 32'd1, 32'd1100, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd2100,
               {1'b1, 32'd1, 32'd2100, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd3100,
               {1'b0, 32'd1, 32'd2100, arc_pkg::STATUS_FAILED, 1'b0, 1'b0, 1'b1});
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd3350,
               {1'b0, 32'd1, 32'd2100, arc_pkg::STATUS_FAILED, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b1, 32'd0, 32'd3600,
               {1'b0, 32'd1, 32'd2100, arc_pkg::STATUS_FAILED, 1'b0, 1'b0, 1'b0});
      // late ack still delivers from the failed state
      add_pass(1, 1'b0, 32'd0, 1'b1, 32'd1, 32'd3850,
               {1'b0, 32'd1, 32'd2100, arc_pkg::STATUS_DELIVERED, 1'b0, 1'b1, 1'b0});
      // press and time at all ones, then both counters wrap
      add_pass(1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'hFFFF_FFFF,
               {1'b1, 32'd2, 32'hFFFF_FFFF, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd998,
               {1'b0, 32'd2, 32'hFFFF_FFFF, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd999,
               {1'b1, 32'd2, 32'd999, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      add_pass(1, 1'b1, 32'd199999, 1'b0, 32'd0, 32'd1500,
               {1'b1, 32'd3, 32'd1500, arc_pkg::STATUS_AWAIT, 1'b1, 1'b0, 1'b0});
      // bounced press with a matching ack in the same pass
      add_pass(1, 1'b1, 32'd399997, 1'b1, 32'd3, 32'd2500,
               {1'b0, 32'd3, 32'd1500, arc_pkg::STATUS_DELIVERED, 1'b0, 1'b1, 1'b0});
      // new press acked in the same pass it is sent
      add_pass(1, 1'b1, 32'd399999, 1'b1, 32'd4, 32'd2600,
               {1'b1, 32'd4, 32'd2600, arc_pkg::STATUS_DELIVERED, 1'b0, 1'b1, 1'b0});
      // zero timeout: a retry follows the press in the same pass
      add_cfg({32'd0, 16'd0, 8'd2});
      add_pass(0, 1'b1, 32'd12345, 1'b0, 32'd0, 32'd7000, '0);
      add_pass(0, 1'b0, 32'd0, 1'b0, 32'd0, 32'd7000, '0);
      // zero attempt budget: a press fails in the same pass; widest debounce
      add_cfg({32'hFFFF_FFFF, 16'd0, 8'd0});
      add_pass(0, 1'b1, 32'd12350, 1'b1, 32'd0, 32'd7250, '0);
      add_pass(0, 1'b1, 32'd12344, 1'b0, 32'd0, 32'd7500, '0);
      // longest timeout, largest budget
      add_cfg({32'd1000, 16'hFFFF, 8'hFF});
      add_pass(0, 1'b1, 32'd20000, 1'b0, 32'd0, 32'd100, '0);
      add_pass(0, 1'b0, 32'd0, 1'b0, 32'd0, 32'd65634, '0);
      add_pass(0, 1'b0, 32'd0, 1'b0, 32'd0, 32'd65635, '0);
      add_pass(0, 1'b1, 32'd20999, 1'b1, 32'd7, 32'd65700, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_passes[i]) begin
         if (directed_passes[i].new_cfg) begin
            load_config(directed_passes[i].cfg);
         end else begin
            want = predict_pass(directed_passes[i].pass);
            if (directed_passes[i].typed) want = directed_passes[i].want;
            drive_pass(directed_passes[i].pass, want);
         end
      end

      // Random phases, each under its own configuration
      now_ms   = 32'd70000;
      press_us = ctl_state.last_press_us;
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p % 4)
            0: c.debounce_us = $urandom_range(0, 3000);
            1: c.debounce_us = arc_pkg::DEBOUNCE_US_RST;
            2: c.debounce_us = '0;
            default: c.debounce_us = $urandom();
         endcase
         case (p % 3)
            0: c.ack_timeout_ms = 16'($urandom_range(0, 40));
            1: c.ack_timeout_ms = 16'($urandom_range(1, 2000));
            default: c.ack_timeout_ms = 16'hFFFF;
         endcase
         c.max_attempts = (p == 5) ? 8'hFF : 8'($urandom_range(0, 5));
         load_config(c);
         // one phase runs with no idling on either side
         send_idle_pct = (p == 3) ? 0 : IDLE_PCT;
         recv_idle_pct = (p == 3) ? 0 : IDLE_PCT;

         for (int n = 0; n < PHASE_PASSES; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: every field random
               it = {1'($urandom()), $urandom(), 1'($urandom()), $urandom(), $urandom()};
               now_ms = it.now_ms;
            end else begin
               // advance time on the scale of the timeout, now and then jump far
               span = 2 * longint'(ctl_cfg.ack_timeout_ms) + 2;
               now_ms += $urandom_range(0, 32'(span));
               if (pick < 14) now_ms += $urandom();
               it.now_ms = now_ms;
               it.press_seen = ($urandom_range(0, 99) < 20);
               span = 2 * longint'(ctl_cfg.debounce_us) + 2;
               if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
               case ($urandom_range(0, 7))
                  0: it.press_time_us = ctl_state.last_press_us + ctl_cfg.debounce_us;
                  1: it.press_time_us = ctl_state.last_press_us + ctl_cfg.debounce_us - 32'd1;
                  2: it.press_time_us = $urandom();
                  default: begin
                     press_us += $urandom_range(0, 32'(span));
                     it.press_time_us = press_us;
                  end
               endcase
               // aim most acks at the live sequence or the one a press makes
               it.ack_valid = ($urandom_range(0, 99) < 30);
               case ($urandom_range(0, 7))
                  0, 1, 2: it.ack_sequence = ctl_state.sequence_count;
                  3, 4:    it.ack_sequence = ctl_state.sequence_count + 32'd1;
                  5:       it.ack_sequence = ctl_state.sequence_count - 32'd1;
                  default: it.ack_sequence = $urandom();
               endcase
            end
            want = predict_pass(it);
            drive_pass(it, want);
         end
      end

      // Drain and let any stray result show up
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4 * RSP_LATENCY) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
